// File: rtl/cdd_pkg.sv
// Shared constants, state type and result packing for the central difference block.
`default_nettype none

package cdd_pkg;

   localparam int WIN_LEN        = 7;
   localparam int OUT_BITS       = 48;
   localparam int QUOT_BITS      = OUT_BITS - 1;
   localparam int INV_BITS       = 16;
   localparam logic [INV_BITS-1:0] INV_RESET = 16'd4096;

   // quotient digit taken per divider step
   localparam int DIGIT_BITS     = 12;

   // f'  = n1 * inv * 4 / 15, rounded
   // f'' = (n2 * inv^2 + 23040) >> 10, then / 45
   localparam int FIRST_DIVISOR  = 15;
   localparam int FIRST_ROUND    = 7;
   localparam int SECOND_DIVISOR = 45;
   localparam int SECOND_SHIFT   = 10;
   localparam int SECOND_ROUND   = 23040;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIFF = 7'b0000010,
      ST_MUL1 = 7'b0000100,
      ST_MUL2 = 7'b0001000,
      ST_PREP = 7'b0010000,
      ST_DIV  = 7'b0100000,
      ST_LOAD = 7'b1000000
   } state_type;

   // Magnitude is at most 2^47; apply sign and clip the positive side.
   function automatic logic signed [OUT_BITS-1:0] pack_result(
      input logic                neg,
      input logic [OUT_BITS-1:0] mag
   );
      logic [OUT_BITS-1:0] res;
      begin
         if (neg) begin
            res = '0 - mag;
         end else if (mag[OUT_BITS-1]) begin
            res = {1'b0, {(OUT_BITS-1){1'b1}}};
         end else begin
            res = mag;
         end
         return $signed(res);
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/cdd_cell.sv
// One window cell: holds a sample and passes it on when a new sample shifts in.
`default_nettype none

module cdd_cell #(
   parameter int WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    shift_en,
   input  logic signed [WIDTH-1:0] data_in,
   output logic signed [WIDTH-1:0] data_out
);

   logic signed [WIDTH-1:0] sample_ff;
   logic signed [WIDTH-1:0] sample_in;

   assign sample_in = shift_en ? data_in : sample_ff;
   assign data_out  = sample_ff;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
   end

endmodule

`default_nettype wire

// File: rtl/cdd_const_div.sv
// Division by a constant, one 12-bit quotient digit per cycle by reciprocal multiplication.
`default_nettype none

module cdd_const_div #(
   parameter int DIVISOR   = 15,
   parameter int DIV_WIDTH = 49
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [DIV_WIDTH-1:0]          dividend,
   output logic                          done,
   output logic [cdd_pkg::OUT_BITS-1:0]  quotient
);

   localparam int QW    = cdd_pkg::QUOT_BITS;
   localparam int CK    = cdd_pkg::DIGIT_BITS;
   localparam int NSTEP = (DIV_WIDTH + CK - 1) / CK;
   localparam int PW    = NSTEP * CK;
   localparam int RW    = $clog2(DIVISOR);
   localparam int VW    = RW + CK;
   localparam int SH    = VW + RW;
   localparam int PRW   = SH + CK;
   localparam int CW    = $clog2(NSTEP);
   // ceil(2^SH / DIVISOR) is exact for every partial dividend below 2^VW
   localparam logic [PRW-1:0] MAGIC =
      PRW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));
   localparam logic [VW-1:0] DIV_K = VW'(DIVISOR);
   localparam logic [CW-1:0] LAST_STEP = CW'(NSTEP - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [RW-1:0]        rem_ff, rem_in;
   logic [PW-1:0]        shf_ff, shf_in;
   logic [VW-1:0]        part;
   logic [PRW-1:0]       prod;
   logic [CK-1:0]        digit;
   logic                 sat;

   assign part  = {rem_ff, shf_ff[PW-1 -: CK]};
   assign prod  = PRW'(part) * MAGIC;
   assign digit = CK'(prod >> SH);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         shf_in  = PW'(dividend);
      end else if (busy_ff) begin
         rem_in = RW'(part - VW'(digit) * DIV_K);
         // dividend digits leave at the top, quotient digits enter at the bottom
         shf_in = {shf_ff[PW-CK-1:0], digit};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
   end

   // quotient needing more than QW bits clips to 2^QW
   assign sat      = |shf_ff[PW-1:QW];
   assign done     = done_ff;
   assign quotient = sat ? {1'b1, {QW{1'b0}}} : {1'b0, shf_ff[QW-1:0]};

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff <= LAST_STEP))
      else $error("divider step count out of range");

endmodule

`default_nettype wire

// File: rtl/central_difference_derivatives.sv
// Top level: seven-sample window and Stirling first/second derivative estimator.
//
// Usage:
//   req_valid/req_ready move one signed sample per transfer into a seven-cell
//   shift chain. The first six samples after reset only fill the window and
//   give no result; from then on every sample gives one result transfer on
//   rsp_valid/rsp_ready carrying f' and f'' at the window center, signed
//   Q32.16, saturated to 48 bits.
//   csr_write_enable/csr_write_data set the reciprocal step (unsigned Q4.12,
//   reset 1.0); write it only while no result is pending.
// Timing:
//   Filling samples are taken one per cycle. A sample that yields a result
//   passes through the DIFF, MUL1, MUL2, PREP, DIV and LOAD states, and no
//   new sample is taken until its result is loaded into the result register.
//   With the default sample width the DIV state runs the five 12-bit digit
//   steps of the two constant dividers, after the difference and multiply stages.
//   The result register frees the core: a stalled receiver blocks new
//   samples only when a second result is ready to be loaded.
// Reset: empties the window count, restores the step register, drops rsp_valid.
`default_nettype none

module central_difference_derivatives #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_BITS-1:0]          req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [cdd_pkg::OUT_BITS-1:0]    rsp_first_derivative,
   output logic signed [cdd_pkg::OUT_BITS-1:0]    rsp_second_derivative,
   input  logic                                   csr_write_enable,
   input  logic [cdd_pkg::INV_BITS-1:0]           csr_write_data
);

   localparam int WL   = cdd_pkg::WIN_LEN;
   localparam int OB   = cdd_pkg::OUT_BITS;
   localparam int IB   = cdd_pkg::INV_BITS;
   localparam int FW   = $clog2(WL + 1);
   localparam int N1W  = SAMPLE_BITS + 8;
   localparam int N2W  = SAMPLE_BITS + 12;
   localparam int M1W  = SAMPLE_BITS + 6;
   localparam int M2W  = SAMPLE_BITS + 10;
   localparam int P1W  = M1W + IB;
   localparam int Q1W  = M2W + IB;
   localparam int Q2W  = M2W + 2 * IB;
   localparam int SW   = Q2W + 1;
   localparam int DW   = (SAMPLE_BITS + 33 > OB) ? SAMPLE_BITS + 33 : OB;

   localparam logic signed [N1W-1:0] K9   = N1W'(9);
   localparam logic signed [N1W-1:0] K45  = N1W'(45);
   localparam logic signed [N2W-1:0] K2   = N2W'(2);
   localparam logic signed [N2W-1:0] K27  = N2W'(27);
   localparam logic signed [N2W-1:0] K270 = N2W'(270);
   localparam logic signed [N2W-1:0] K490 = N2W'(490);
   localparam logic [FW-1:0] FILL_FULL = FW'(WL);
   localparam logic [FW-1:0] FILL_LAST = FW'(WL - 1);

   cdd_pkg::state_type state_ff, state_in;

   logic [FW-1:0] fill_ff, fill_in;
   logic [IB-1:0] inv_ff, inv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept, produce, load;

   logic signed [SAMPLE_BITS-1:0] win [WL];
   logic signed [N1W-1:0] e1 [WL];
   logic signed [N2W-1:0] e2 [WL];
   logic signed [N1W-1:0] n1;
   logic signed [N2W-1:0] n2;
   logic [N1W-1:0] abs1;
   logic [N2W-1:0] abs2;

   logic [M1W-1:0] mag1_ff;
   logic [M2W-1:0] mag2_ff;
   logic           neg1_ff, neg2_ff;
   logic [P1W-1:0] prod1_ff;
   logic [Q1W-1:0] p1_ff;
   logic [Q2W-1:0] p2_ff;
   logic [SW-1:0]  sum2;
   logic [DW-1:0]  x1, x2;

   logic           div_start, div1_done, div2_done;
   logic [OB-1:0]  q1, q2;
   logic signed [OB-1:0] fd_ff, sd_ff;

   // window: cell WL-1 takes the new sample, cell 0 is the oldest
   for (genvar i = 0; i < WL; i++) begin : g_cell
      if (i == WL - 1) begin : g_head
         cdd_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
            .clock    (clock),
            .shift_en (accept),
            .data_in  (req_sample),
            .data_out (win[i])
         );
      end else begin : g_body
         cdd_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
            .clock    (clock),
            .shift_en (accept),
            .data_in  (win[i+1]),
            .data_out (win[i])
         );
      end
      assign e1[i] = N1W'(win[i]);
      assign e2[i] = N2W'(win[i]);
   end

   assign accept  = req_valid & req_ready;
   assign produce = (fill_ff >= FILL_LAST);
   assign load    = (state_ff == cdd_pkg::ST_LOAD) && (!rsp_valid_ff || rsp_ready);

   // 60 * first-derivative bracket and 180 * second-derivative bracket
   assign n1 = (e1[6] - e1[0]) + K9 * (e1[1] - e1[5]) + K45 * (e1[4] - e1[2]);
   assign n2 = K2 * (e2[6] + e2[0]) - K27 * (e2[5] + e2[1])
             + K270 * (e2[4] + e2[2]) - K490 * e2[3];
   assign abs1 = n1[N1W-1] ? N1W'(-n1) : N1W'(n1);
   assign abs2 = n2[N2W-1] ? N2W'(-n2) : N2W'(n2);

   assign sum2 = SW'(p2_ff) + SW'(cdd_pkg::SECOND_ROUND);
   assign x1   = DW'({prod1_ff, 2'b00}) + DW'(cdd_pkg::FIRST_ROUND);
   assign x2   = DW'(sum2 >> cdd_pkg::SECOND_SHIFT);
   assign div_start = (state_ff == cdd_pkg::ST_PREP);

   cdd_const_div #(.DIVISOR(cdd_pkg::FIRST_DIVISOR), .DIV_WIDTH(DW)) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (x1),
      .done     (div1_done),
      .quotient (q1)
   );

   cdd_const_div #(.DIVISOR(cdd_pkg::SECOND_DIVISOR), .DIV_WIDTH(DW)) u_div2 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (x2),
      .done     (div2_done),
      .quotient (q2)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cdd_pkg::ST_IDLE: begin
            if (accept && produce) state_in = cdd_pkg::ST_DIFF;
         end
         cdd_pkg::ST_DIFF: state_in = cdd_pkg::ST_MUL1;
         cdd_pkg::ST_MUL1: state_in = cdd_pkg::ST_MUL2;
         cdd_pkg::ST_MUL2: state_in = cdd_pkg::ST_PREP;
         cdd_pkg::ST_PREP: state_in = cdd_pkg::ST_DIV;
         cdd_pkg::ST_DIV: begin
            if (div1_done) state_in = cdd_pkg::ST_LOAD;
         end
         cdd_pkg::ST_LOAD: begin
            if (load) state_in = cdd_pkg::ST_IDLE;
         end
         default: state_in = cdd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept && (fill_ff != FILL_FULL)) fill_in = fill_ff + 1'b1;
      inv_in = csr_write_enable ? csr_write_data : inv_ff;
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdd_pkg::ST_IDLE;
         fill_ff      <= '0;
         inv_ff       <= cdd_pkg::INV_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == cdd_pkg::ST_DIFF) begin
         mag1_ff <= abs1[M1W-1:0];
         mag2_ff <= abs2[M2W-1:0];
         neg1_ff <= n1[N1W-1];
         neg2_ff <= n2[N2W-1];
      end
      if (state_ff == cdd_pkg::ST_MUL1) begin
         prod1_ff <= P1W'(mag1_ff) * P1W'(inv_ff);
         p1_ff    <= Q1W'(mag2_ff) * Q1W'(inv_ff);
      end
      if (state_ff == cdd_pkg::ST_MUL2) begin
         p2_ff <= Q2W'(p1_ff) * Q2W'(inv_ff);
      end
      if (load) begin
         fd_ff <= cdd_pkg::pack_result(neg1_ff, q1);
         sd_ff <= cdd_pkg::pack_result(neg2_ff, q2);
      end
   end

   assign req_ready             = (state_ff == cdd_pkg::ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_first_derivative  = fd_ff;
   assign rsp_second_derivative = sd_ff;

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div1_done == div2_done)
      else $error("constant dividers out of step");

   a_full_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cdd_pkg::ST_DIFF) |-> (fill_ff == FILL_FULL))
      else $error("derivative started on a partial window");

   a_start_result: assert property (@(posedge clock) disable iff (reset)
      (accept && produce) |=> (state_ff == cdd_pkg::ST_DIFF))
      else $error("full-window sample did not start a result");

endmodule

`default_nettype wire

// File: tb/sv/tb_central_difference_derivatives.sv
// Self-checking testbench for the Stirling central difference derivative block.
`timescale 1ns / 100ps

module tb_central_difference_derivatives;

   localparam int SAMPLE_W     = 16;
   localparam int DRAIN_CYCLES = 64;
   localparam int MAX_REPORTS  = 10;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_HALF,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   typedef struct packed {
      logic signed [cdd_pkg::OUT_BITS-1:0] first;
      logic signed [cdd_pkg::OUT_BITS-1:0] second;
   } derivative_pair_type;

   logic                                 clock;
   logic                                 reset;
   logic                                 req_valid;
   logic                                 req_ready;
   logic signed [SAMPLE_W-1:0]           req_sample;
   logic                                 rsp_valid;
   logic                                 rsp_ready;
   logic signed [cdd_pkg::OUT_BITS-1:0]  rsp_first_derivative;
   logic signed [cdd_pkg::OUT_BITS-1:0]  rsp_second_derivative;
   logic                                 csr_write_enable;
   logic [cdd_pkg::INV_BITS-1:0]         csr_write_data;

   // predictor state
   logic signed [SAMPLE_W-1:0]    sample_hist [cdd_pkg::WIN_LEN];
   int                            fill_level;
   logic [cdd_pkg::INV_BITS-1:0]  cur_inv_step;
   derivative_pair_type           pending_derivatives [$];

   int                            error_count;
   int                            burst_left;
   bit                            offering;
   int                            walk_value;
   int                            walk_slope;

   // receiver pattern
   int                            hold_request;
   int                            hold_left;
   int                            rx_phase_left;
   rx_mode_type                   rx_mode;

   central_difference_derivatives #(
      .SAMPLE_BITS(SAMPLE_W)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_sample           (req_sample),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_first_derivative (rsp_first_derivative),
      .rsp_second_derivative(rsp_second_derivative),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   function automatic logic signed [cdd_pkg::OUT_BITS-1:0] saturate_q16(
      input bit              neg,
      input longint unsigned mag
   );
      longint unsigned t;
      begin
         if (neg) begin
            if (mag > 64'h0000_8000_0000_0000) mag = 64'h0000_8000_0000_0000;
            t = 64'd0 - mag;
         end else begin
            if (mag > 64'h0000_7FFF_FFFF_FFFF) mag = 64'h0000_7FFF_FFFF_FFFF;
            t = mag;
         end
         return t[cdd_pkg::OUT_BITS-1:0];
      end
   endfunction

   // f' and f'' at the center of the current window
   function automatic derivative_pair_type stirling_predict(
      input logic [cdd_pkg::INV_BITS-1:0] inv
   );
      longint              w [cdd_pkg::WIN_LEN];
      longint              a, b, c, n1, d2, d4, d6, n2;
      longint unsigned     step, mag, prod, quo, rmd, rnd;
      derivative_pair_type res;
      begin
         for (int i = 0; i < cdd_pkg::WIN_LEN; i++) w[i] = sample_hist[i];
         step = {48'd0, inv};
         a  = w[4] - w[2];
         b  = w[5] - 2 * w[4] + 2 * w[2] - w[1];
         c  = w[6] - 4 * w[5] + 5 * w[4] - 5 * w[2] + 4 * w[1] - w[0];
         n1 = 30 * a - 5 * b + c;
         d2 = w[4] - 2 * w[3] + w[2];
         d4 = w[5] - 4 * w[4] + 6 * w[3] - 4 * w[2] + w[1];
         d6 = w[6] - 6 * w[5] + 15 * w[4] - 20 * w[3] + 15 * w[2] - 6 * w[1] + w[0];
         n2 = 180 * d2 - 15 * d4 + 2 * d6;

         mag = (n1 < 0) ? -n1 : n1;
         quo = (mag * step * 4 + 7) / 15;
         res.first = saturate_q16(n1 < 0, quo);

         // split the division so inv^2 scaling rounds once
         mag  = (n2 < 0) ? -n2 : n2;
         prod = mag * step;
         quo  = prod / 46080;
         rmd  = prod % 46080;
         rnd  = rmd * step + 23040;
         quo  = quo * step + rnd / 46080;
         res.second = saturate_q16(n2 < 0, quo);
         return res;
      end
   endfunction

   task automatic window_accept(input logic signed [SAMPLE_W-1:0] s);
      begin
         for (int i = 0; i < cdd_pkg::WIN_LEN - 1; i++) sample_hist[i] = sample_hist[i + 1];
         sample_hist[cdd_pkg::WIN_LEN - 1] = s;
         if (fill_level < cdd_pkg::WIN_LEN) fill_level++;
         if (fill_level == cdd_pkg::WIN_LEN)
            pending_derivatives.push_back(stirling_predict(cur_inv_step));
      end
   endtask

   // one sample transfer; bursts with random gaps between them
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
      int gap;
      begin
         if (burst_left == 0) begin
            if (offering) begin
               req_valid <= 1'b0;
               offering = 1'b0;
            end
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
            repeat (gap) @(posedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
         end
         req_valid  <= 1'b1;
         req_sample <= s;
         offering = 1'b1;
         @(posedge clock);
         while (!req_ready) @(posedge clock);
         window_accept(s);
         burst_left--;
      end
   endtask

   task automatic sender_idle();
      begin
         if (offering) begin
            req_valid <= 1'b0;
            offering = 1'b0;
         end
         burst_left = 0;
      end
   endtask

   task automatic wait_drained();
      begin
         sender_idle();
         while (pending_derivatives.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
      end
   endtask

   task automatic write_inv_step(input logic [cdd_pkg::INV_BITS-1:0] v);
      begin
         wait_drained();
         csr_write_enable <= 1'b1;
         csr_write_data   <= v;
         @(posedge clock);
         csr_write_enable <= 1'b0;
         cur_inv_step = v;
      end
   endtask

   function automatic logic signed [SAMPLE_W-1:0] next_sample();
      int pick;
      begin
         pick = $urandom_range(0, 9);
         if (pick < 4) return SAMPLE_W'($urandom());
         if (pick == 4) begin
            case ($urandom_range(0, 3))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               default: return 16'shFFFF;
            endcase
         end
         // smooth walk so the higher differences stay small
         walk_slope = walk_slope + int'($urandom_range(0, 64)) - 32;
         if (walk_slope > 2000) walk_slope = 2000;
         if (walk_slope < -2000) walk_slope = -2000;
         walk_value = walk_value + walk_slope;
         if (walk_value > 32767) begin
            walk_value = 32767;
            walk_slope = -walk_slope;
         end
         if (walk_value < -32768) begin
            walk_value = -32768;
            walk_slope = -walk_slope;
         end
         return walk_value[SAMPLE_W-1:0];
      end
   endfunction

   // receiver: phases of its own pattern, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_phase_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_phase_left = $urandom_range(20, 300);
         end
         rx_phase_left--;
         case (rx_mode)
            RX_ALWAYS:   rsp_ready <= 1'b1;
            RX_HALF:     rsp_ready <= ($urandom_range(0, 1) == 1);
            RX_SPARSE:   rsp_ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: rsp_ready <= (rx_phase_left % 5 == 0);
            default:     rsp_ready <= 1'b1;
         endcase
      end
   end

   // result checker
   always @(posedge clock) begin
      derivative_pair_type exp_pair;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_derivatives.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result transfer: f'=%0d f''=%0d",
                        rsp_first_derivative, rsp_second_derivative);
         end else begin
            exp_pair = pending_derivatives.pop_front();
            if (rsp_first_derivative !== exp_pair.first ||
                rsp_second_derivative !== exp_pair.second) begin
               error_count++;
               if (error_count <= MAX_REPORTS)
                  $display("mismatch: f' exp %0d got %0d, f'' exp %0d got %0d",
                           exp_pair.first, rsp_first_derivative,
                           exp_pair.second, rsp_second_derivative);
            end
         end
      end
   end

   task automatic test_fill_window();
      begin
         // six fill samples give nothing; the seventh gives the first result
         for (int i = 0; i < cdd_pkg::WIN_LEN; i++)
            send_sample((i % 2 == 0) ? 16'sh7FFF : 16'sh8000);
      end
   endtask

   task automatic test_step_extremes();
      logic [cdd_pkg::INV_BITS-1:0] steps [3];
      begin
         steps[0] = 16'hFFFF;
         steps[1] = 16'h0001;
         steps[2] = 16'h0000;
         for (int k = 0; k < 3; k++) begin
            write_inv_step(steps[k]);
            send_sample(16'sh8000);
            send_sample(16'sh7FFF);
            send_sample(16'sh0000);
            send_sample(SAMPLE_W'($urandom()));
         end
         write_inv_step(cdd_pkg::INV_RESET);
         send_sample(16'shFFFF);
         send_sample(16'sh7FFF);
      end
   endtask

   task automatic test_backpressure();
      begin
         wait_drained();
         hold_request = 1500;
         burst_left = 1000;
         for (int i = 0; i < 6; i++) send_sample(next_sample());
      end
   endtask

   task automatic test_random_phases();
      int                           count;
      logic [cdd_pkg::INV_BITS-1:0] inv;
      begin
         for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
               0: inv = 16'h0001;
               1: inv = 16'hFFFF;
               2: inv = cdd_pkg::INV_RESET;
               default: inv = cdd_pkg::INV_BITS'($urandom_range(1, 65535));
            endcase
            write_inv_step(inv);
            count = $urandom_range(170, 215);
            for (int i = 0; i < count; i++) send_sample(next_sample());
         end
      end
   endtask

   initial begin
      int wait_cycles;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample       = '0;
      rsp_ready        = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      for (int i = 0; i < cdd_pkg::WIN_LEN; i++) sample_hist[i] = '0;
      fill_level    = 0;
      cur_inv_step  = cdd_pkg::INV_RESET;
      error_count   = 0;
      burst_left    = 0;
      offering      = 1'b0;
      walk_value    = 0;
      walk_slope    = 0;
      hold_request  = 0;
      hold_left     = 0;
      rx_phase_left = 0;
      rx_mode       = RX_ALWAYS;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_window();
      test_step_extremes();
      test_backpressure();
      test_random_phases();

      sender_idle();
      wait_cycles = 0;
      while (pending_derivatives.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_derivatives.size() != 0) error_count++;

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
